// ===== rtl/pfc_pkg.sv =====
// Shared types, constants and helper functions for the pixel format converter.
// Used by pfc_div, pixel_format_converter and tb; depends on nothing else.
package pfc_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  shamt_t;

  localparam int QUOT_W             = 32;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;
  localparam int NUM_CH             = 3;

  typedef enum logic [2:0] {
    CFG_SRC_RED   = 3'd0,
    CFG_SRC_GREEN = 3'd1,
    CFG_SRC_BLUE  = 3'd2,
    CFG_DST_RED   = 3'd3,
    CFG_DST_GREEN = 3'd4,
    CFG_DST_BLUE  = 3'd5,
    CFG_SRC_TAG   = 3'd6,
    CFG_DST_TAG   = 3'd7
  } cfg_idx_t;

  // Side information that travels down the pipeline next to the channel data.
  typedef struct packed {
    logic  vld;
    logic  ident;
    logic  bad;
    word_t pix;
  } side_t;

  // Number of trailing zeros of a mask; an empty mask gives zero.
  function automatic shamt_t mask_shift(word_t m);
    shamt_t s;
    s = '0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) begin
        s = shamt_t'(i);
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/pfc_div.sv =====
// Pipelined restoring divider: 64-bit dividend over a 32-bit divisor, 32-bit quotient.
// The dividend's upper half must be below the divisor. Depends on pfc_pkg.
module pfc_div (
  input  logic           clk,
  input  logic           en,
  input  pfc_pkg::word_t divisor,
  input  logic [63:0]    dividend,
  output pfc_pkg::word_t quot
);
  import pfc_pkg::*;

  word_t rem_r [DIV_STAGES];
  word_t lo_r  [DIV_STAGES];
  word_t q_r   [DIV_STAGES];
  word_t rem_nxt [DIV_STAGES];
  word_t lo_nxt  [DIV_STAGES];
  word_t q_nxt   [DIV_STAGES];

  // Each stage retires DIV_BITS_PER_STAGE quotient bits.
  always_comb begin
    word_t       rem;
    word_t       lo;
    word_t       q;
    logic [32:0] t;
    for (int st = 0; st < DIV_STAGES; st++) begin
      if (st == 0) begin
        rem = dividend[63:32];
        lo  = dividend[31:0];
        q   = '0;
      end else begin
        rem = rem_r[st-1];
        lo  = lo_r[st-1];
        q   = q_r[st-1];
      end
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        t  = {rem, lo[31]};
        lo = {lo[30:0], 1'b0};
        if (t >= {1'b0, divisor}) begin
          t   = t - {1'b0, divisor};
          rem = t[31:0];
          q   = {q[30:0], 1'b1};
        end else begin
          rem = t[31:0];
          q   = {q[30:0], 1'b0};
        end
      end
      rem_nxt[st] = rem;
      lo_nxt[st]  = lo;
      q_nxt[st]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int st = 0; st < DIV_STAGES; st++) begin
        rem_r[st] <= rem_nxt[st];
        lo_r[st]  <= lo_nxt[st];
        q_r[st]   <= q_nxt[st];
      end
    end
  end

  assign quot = q_r[DIV_STAGES-1];

endmodule

// ===== rtl/pixel_format_converter.sv =====
// Top level of the pixel format converter: configuration registers and pipeline.
// Depends on pfc_pkg and pfc_div.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    in_src_pixel
//   out_      output     out_valid / out_stall  out_dst_pixel, out_bad_format
//   cfg_      input      cfg_wr_en              cfg_index, cfg_wdata
//
// One request per cycle unless the output stalls. Stages: extract, multiply, the
// divider (four quotient bits per stage, three channels) and the output register.
// Reset is synchronous and clears all valid bits and loads the default formats.
// A stall with out_valid high freezes the pipeline; in_stall rises in the same cycle.
module pixel_format_converter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfc_pkg::word_t in_src_pixel,
  output logic           out_valid,
  input  logic           out_stall,
  output pfc_pkg::word_t out_dst_pixel,
  output logic           out_bad_format,
  input  logic           cfg_wr_en,
  input  logic [2:0]     cfg_index,
  input  pfc_pkg::word_t cfg_wdata
);
  import pfc_pkg::*;

  // Masks, shifts and maxima: entries 0..2 source RGB, 3..5 destination RGB.
  word_t      mask_r [6];
  word_t      max_r  [6];
  shamt_t     sh_r   [6];
  logic [6:0] src_tag_r;
  logic [6:0] dst_tag_r;

  logic       advance;
  logic       ident;
  logic       any_zero;

  side_t       s1_side_r;
  word_t       s1_c_r  [NUM_CH];
  side_t       s2_side_r;
  logic [63:0] prod_r  [NUM_CH];
  side_t       dly_r   [DIV_STAGES];
  word_t       quot    [NUM_CH];
  word_t       packed_pix;

  logic  out_valid_r;
  word_t out_dst_pixel_r;
  logic  out_bad_format_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= 32'h00FF_0000;
      mask_r[1] <= 32'h0000_FF00;
      mask_r[2] <= 32'h0000_00FF;
      mask_r[3] <= 32'h00FF_0000;
      mask_r[4] <= 32'h0000_FF00;
      mask_r[5] <= 32'h0000_00FF;
      max_r[0]  <= 32'h0000_00FF;
      max_r[1]  <= 32'h0000_00FF;
      max_r[2]  <= 32'h0000_00FF;
      max_r[3]  <= 32'h0000_00FF;
      max_r[4]  <= 32'h0000_00FF;
      max_r[5]  <= 32'h0000_00FF;
      sh_r[0]   <= 5'd16;
      sh_r[1]   <= 5'd8;
      sh_r[2]   <= 5'd0;
      sh_r[3]   <= 5'd16;
      sh_r[4]   <= 5'd8;
      sh_r[5]   <= 5'd0;
      src_tag_r <= 7'd96;
      dst_tag_r <= 7'd96;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_RED, CFG_SRC_GREEN, CFG_SRC_BLUE,
        CFG_DST_RED, CFG_DST_GREEN, CFG_DST_BLUE: begin
          mask_r[cfg_index] <= cfg_wdata;
          sh_r[cfg_index]   <= mask_shift(cfg_wdata);
          max_r[cfg_index]  <= cfg_wdata >> mask_shift(cfg_wdata);
        end
        CFG_SRC_TAG: begin
          src_tag_r <= cfg_wdata[6:0];
        end
        CFG_DST_TAG: begin
          dst_tag_r <= cfg_wdata[6:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  assign ident = (mask_r[0] == mask_r[3]) && (mask_r[1] == mask_r[4]) &&
                 (mask_r[2] == mask_r[5]) && (src_tag_r == dst_tag_r);
  assign any_zero = (max_r[0] == '0) || (max_r[1] == '0) || (max_r[2] == '0);

  // Stage 1: extract channels. Stage 2: multiply by destination maxima.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.vld <= 1'b0;
      s2_side_r.vld <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        dly_r[i].vld <= 1'b0;
      end
    end else if (advance) begin
      s1_side_r.vld   <= in_valid;
      s1_side_r.ident <= ident;
      s1_side_r.bad   <= !ident && any_zero;
      s1_side_r.pix   <= in_src_pixel;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s1_c_r[ch] <= (in_src_pixel >> sh_r[ch]) & max_r[ch];
        prod_r[ch] <= 64'(s1_c_r[ch]) * 64'(max_r[ch+3]);
      end
      s2_side_r <= s1_side_r;
      dly_r[0]  <= s2_side_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_div
    pfc_div u_div (
      .clk      (clk),
      .en       (advance),
      .divisor  (max_r[ch]),
      .dividend (prod_r[ch]),
      .quot     (quot[ch])
    );
  end

  // A channel with an empty source mask contributes nothing.
  always_comb begin
    packed_pix = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (max_r[ch] != '0) begin
        packed_pix = packed_pix | (quot[ch] << sh_r[ch+3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r      <= dly_r[DIV_STAGES-1].vld;
      out_dst_pixel_r  <= dly_r[DIV_STAGES-1].ident ? dly_r[DIV_STAGES-1].pix : packed_pix;
      out_bad_format_r <= dly_r[DIV_STAGES-1].bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dst_pixel  = out_dst_pixel_r;
  assign out_bad_format = out_bad_format_r;

`ifndef SYNTHESIS
  a_bad_not_ident: assert property (@(posedge clk) disable iff (!rst_n)
    dly_r[DIV_STAGES-1].vld && dly_r[DIV_STAGES-1].bad |-> !dly_r[DIV_STAGES-1].ident)
    else $error("identity request flagged as bad format");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !advance |=> $stable(s1_side_r.vld) && $stable(s2_side_r.vld) &&
      $stable(dly_r[DIV_STAGES-1].vld) && $stable(out_valid_r))
    else $error("pipeline valid bits moved during a stall");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_side_r.vld && !s2_side_r.vld && !dly_r[0].vld)
    else $error("valid bits not cleared by reset");
`endif

endmodule

// ===== dv/tb.sv =====
// Testbench for pixel_format_converter: random and directed pixels under many formats.
// Depends on pfc_pkg and the converter RTL; predicts each result and checks it in order.
`timescale 1ns / 1ps

module tb;
  import pfc_pkg::*;

  localparam int LATENCY = DIV_STAGES + 3;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  word_t       in_src_pixel;
  logic        out_valid;
  logic        out_stall;
  word_t       out_dst_pixel;
  logic        out_bad_format;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  word_t       cfg_wdata;

  typedef struct {
    word_t pix;
    logic  bad;
  } conv_result_t;

  word_t        fmt_regs[8];
  word_t        pixel_queue[$];
  conv_result_t expected_pixels[$];
  int           n_errors = 0;
  int           n_checked = 0;
  int           n_bad_seen = 0;
  longint       cycle_count = 0;
  int           burst_left;
  int           gap_left;
  int           hold_off;
  bit           hold_req;
  bit           stall_pattern_on;

  pixel_format_converter i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_src_pixel,
    .out_valid, .out_stall, .out_dst_pixel, .out_bad_format,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int trailing_zeros(word_t m);
    int s;
    s = 0;
    if (m == '0) return 0;
    while (!m[s]) s++;
    return s;
  endfunction

  function automatic logic [31:0] scale_channel(word_t pix, word_t smask, word_t dmask,
                                                inout logic bad);
    word_t   smax;
    word_t   dmax;
    logic [63:0] c;
    logic [63:0] q;
    smax = smask >> trailing_zeros(smask);
    dmax = dmask >> trailing_zeros(dmask);
    if (smax == '0) begin
      bad = 1'b1;
      return '0;
    end
    c = 64'((pix >> trailing_zeros(smask)) & smax);
    q = (c * 64'(dmax)) / 64'(smax);
    return 32'(q << trailing_zeros(dmask));
  endfunction

  function automatic conv_result_t convert_pixel(word_t pix);
    conv_result_t r;
    logic bad;
    bad = 1'b0;
    if (fmt_regs[CFG_SRC_RED] == fmt_regs[CFG_DST_RED] &&
        fmt_regs[CFG_SRC_GREEN] == fmt_regs[CFG_DST_GREEN] &&
        fmt_regs[CFG_SRC_BLUE] == fmt_regs[CFG_DST_BLUE] &&
        fmt_regs[CFG_SRC_TAG] == fmt_regs[CFG_DST_TAG]) begin
      r.pix = pix;
    end else begin
      r.pix = scale_channel(pix, fmt_regs[CFG_SRC_RED], fmt_regs[CFG_DST_RED], bad)
            | scale_channel(pix, fmt_regs[CFG_SRC_GREEN], fmt_regs[CFG_DST_GREEN], bad)
            | scale_channel(pix, fmt_regs[CFG_SRC_BLUE], fmt_regs[CFG_DST_BLUE], bad);
    end
    r.bad = bad;
    return r;
  endfunction

  // Driver: bursts of requests with random gaps. An accepted request leaves the queue
  // at once, so the head of the queue is always the next one to offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_src_pixel <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_pixels = {expected_pixels, convert_pixel(in_src_pixel)};
        void'(pixel_queue.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_src_pixel <= pixel_queue[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: its own pattern plus one long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_off <= 0;
    end else if (hold_req && hold_off == 0) begin
      hold_off <= 60;
      out_stall <= 1'b1;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      if (hold_off == 1) hold_off <= -1;
      out_stall <= stall_pattern_on ? ($urandom_range(3, 0) == 0) : 1'b0;
    end
  end

  // Monitor: compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result dst_pixel=%h", out_dst_pixel);
        n_errors++;
      end else begin
        conv_result_t e;
        e = expected_pixels.pop_front();
        if (out_dst_pixel !== e.pix) begin
          $error("dst_pixel expected %h actual %h", e.pix, out_dst_pixel);
          n_errors++;
        end
        if (out_bad_format !== e.bad) begin
          $error("bad_format expected %0b actual %0b", e.bad, out_bad_format);
          n_errors++;
        end
        n_checked++;
        if (e.bad) n_bad_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // A write raises enable, then lowers it and idles before returning, so that enable changes only once per clock edge.
  task automatic write_reg(cfg_idx_t idx, word_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fmt_regs[idx] = (idx == CFG_SRC_TAG || idx == CFG_DST_TAG) ? (val & 32'h7f) : val;
    @(posedge clk);
  endtask

  task automatic add_pixel(word_t p);
    pixel_queue = {pixel_queue, p};
  endtask

  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic word_t random_mask();
    int lo;
    int w;
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: begin
        lo = $urandom_range(31, 0);
        w = $urandom_range(32 - lo, 1);
        return word_t'(((64'd1 << w) - 1) << lo);
      end
    endcase
  endfunction

  function automatic word_t random_pixel();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_pixels(int n);
    repeat (n) add_pixel(random_pixel());
  endtask

  initial begin
    word_t m;
    rst_n = 1'b0;
    hold_req = 1'b0;
    stall_pattern_on = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SRC_RED;
    cfg_wdata = '0;
    fmt_regs[CFG_SRC_RED] = 32'h00ff0000;
    fmt_regs[CFG_SRC_GREEN] = 32'h0000ff00;
    fmt_regs[CFG_SRC_BLUE] = 32'h000000ff;
    fmt_regs[CFG_DST_RED] = 32'h00ff0000;
    fmt_regs[CFG_DST_GREEN] = 32'h0000ff00;
    fmt_regs[CFG_DST_BLUE] = 32'h000000ff;
    fmt_regs[CFG_SRC_TAG] = 32'd96;
    fmt_regs[CFG_DST_TAG] = 32'd96;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pass-through at reset formats, then 888 to 565 and gapped/zero masks.
    add_pixel('0);
    add_pixel('1);
    add_pixel(32'h12345678);
    drain();
    write_reg(CFG_DST_RED, 32'h0000f800);
    write_reg(CFG_DST_GREEN, 32'h000007e0);
    write_reg(CFG_DST_BLUE, 32'h0000001f);
    write_reg(CFG_DST_TAG, 32'd16);
    add_pixel('0);
    add_pixel('1);
    add_pixel(32'h00ff0000);
    add_pixel(32'h00808080);
    drain();
    // Zero source mask on green, gapped red, full-width blue.
    write_reg(CFG_SRC_GREEN, '0);
    write_reg(CFG_SRC_RED, 32'h00f0f000);
    write_reg(CFG_SRC_BLUE, '1);
    write_reg(CFG_DST_BLUE, '1);
    write_reg(CFG_DST_GREEN, '0);
    write_reg(CFG_SRC_TAG, 32'd127);
    add_pixel('0);
    add_pixel('1);
    add_pixel(32'haaaaaaaa);
    add_pixel(32'h55555555);
    drain();
    // Identical formats with a zero mask still pass through without the flag.
    write_reg(CFG_DST_RED, 32'h00f0f000);
    write_reg(CFG_DST_GREEN, '0);
    write_reg(CFG_DST_TAG, 32'd127);
    add_pixel(32'hdeadbeef);
    add_pixel('1);
    drain();
    write_reg(CFG_SRC_TAG, '0);
    write_reg(CFG_DST_TAG, 32'd64);
    add_pixel(32'hdeadbeef);
    drain();

    // Long hold-off so the pipeline fills and stalls its input.
    queue_pixels(60);
    hold_req = 1'b1;
    while (hold_off == 0) @(posedge clk);
    hold_req = 1'b0;
    drain();

    stall_pattern_on = 1'b1;
    for (int phase = 0; phase < 14; phase++) begin
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(2, 0) != 0) begin
          m = (r >= CFG_SRC_TAG) ? word_t'($urandom_range(127, 0)) : random_mask();
          // Sometimes copy the source side to reach the pass-through path.
          if (r >= CFG_DST_RED && r <= CFG_DST_BLUE && $urandom_range(3, 0) == 0)
            m = fmt_regs[r - 3];
          write_reg(cfg_idx_t'(r), m);
        end
      end
      if ($urandom_range(4, 0) == 0) write_reg(CFG_DST_TAG, fmt_regs[CFG_SRC_TAG]);
      stall_pattern_on = (phase % 4) != 3;
      queue_pixels(50);
      drain();
    end

    $display("checked %0d pixels over 14 random formats plus directed cases", n_checked);
    $display("%0d results carried the bad format flag", n_bad_seen);
    if (n_errors == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfc_pkg.sv
rtl/pfc_div.sv
rtl/pixel_format_converter.sv
dv/tb.sv
